FILE: src/pbg_pkg.sv
// shared types and constants for the pushbroom pixel to ground pipeline
package pbg_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ANGLE_PER_PIXEL  = 2'd0,
    CFG_LINE_PIXELS      = 2'd1,
    CFG_GROUND_ELEVATION = 2'd2
  } cfg_index_t;

  // quadrant of a reduced angle
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  localparam logic [31:0] ANGLE_PER_PIXEL_RST  = 32'd125404000;
  localparam logic [15:0] LINE_PIXELS_RST      = 16'd6144;
  localparam logic [31:0] GROUND_ELEVATION_RST = 32'd265216;

  // angle reduction, radians q28
  localparam logic [30:0] RED_PERIOD = 31'd1686629712;
  localparam logic [9:0]  RED_RECIP  = 10'd651;
  localparam logic [28:0] HPI_Q28    = 29'd421657428;
  localparam logic [27:0] QPI_Q28    = 28'd210828714;
  localparam logic [30:0] HPI2_Q28   = 31'd843314856;
  localparam logic [30:0] HPI3_Q28   = 31'd1264972284;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // taylor horner divisors
  localparam int SIN_TERMS = 5;
  localparam int COS_TERMS = 6;
  localparam int SIN_K [SIN_TERMS] = '{110, 72, 42, 20, 6};
  localparam int COS_K [COS_TERMS] = '{132, 90, 56, 30, 12, 2};

  localparam int CELL_LAT = 3;
  localparam int SC_LAT   = 5 + 1 + COS_TERMS * CELL_LAT + 1;

  function automatic logic [47:0] sat48(input logic signed [48:0] v);
    logic [47:0] r;
    if (v[48] != v[47]) begin
      r = v[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

FILE: src/pbg_reduce.sv
// angle reduction modulo two pi and fold into the first octant
module pbg_reduce import pbg_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [39:0] angle,
  output logic [27:0]        y28,
  output quad_t              quad,
  output logic               swap
);

  logic signed [50:0] pm;
  logic signed [39:0] a1;
  logic signed [10:0] qe1;
  logic signed [42:0] diff;
  logic signed [32:0] r2;
  logic [30:0]        r3;
  logic [32:0]        r2p;
  logic [32:0]        r2m;
  quad_t              q4;
  quad_t              q4_next;
  logic [30:0]        sub4;
  logic [28:0]        x4;

  assign pm   = angle * $signed({1'b0, RED_RECIP});
  assign diff = 43'(a1) - qe1 * $signed({1'b0, RED_PERIOD});
  assign r2p  = r2 + {2'b00, RED_PERIOD};
  assign r2m  = r2 - {2'b00, RED_PERIOD};

  always_comb begin
    if (r3 >= HPI3_Q28) begin
      q4_next = QUAD_3;
      sub4    = HPI3_Q28;
    end else if (r3 >= HPI2_Q28) begin
      q4_next = QUAD_2;
      sub4    = HPI2_Q28;
    end else if (r3 >= 31'(HPI_Q28)) begin
      q4_next = QUAD_1;
      sub4    = 31'(HPI_Q28);
    end else begin
      q4_next = QUAD_0;
      sub4    = 31'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= angle;
      qe1 <= $signed(pm[50:40]);
      r2  <= $signed(diff[32:0]);
      if (r2[32]) begin
        r3 <= r2p[30:0];
      end else if (r2[31:0] >= {1'b0, RED_PERIOD}) begin
        r3 <= r2m[30:0];
      end else begin
        r3 <= r2[30:0];
      end
      q4 <= q4_next;
      x4 <= 29'(r3 - sub4);
      quad <= q4;
      if (x4 > 29'(QPI_Q28)) begin
        y28  <= 28'(HPI_Q28 - x4);
        swap <= 1'b1;
      end else begin
        y28  <= x4[27:0];
        swap <= 1'b0;
      end
    end
  end

endmodule

FILE: src/pbg_cell.sv
// one horner step cell: t_out = 1 - (z * t_in) / K
module pbg_cell import pbg_pkg::*; #(
  parameter int K = 2
) (
  input  logic        clk,
  input  logic        en,
  input  logic [29:0] z_in,
  input  logic [30:0] t_in,
  output logic [29:0] z_out,
  output logic [30:0] t_out
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
  localparam logic [7:0]  KV    = 8'(K);

  logic [60:0] mz;
  logic [29:0] p1;
  logic [29:0] z1;
  logic [61:0] pr;
  logic [29:0] qe2;
  logic [29:0] p2;
  logic [29:0] z2;
  logic [37:0] rem;
  logic        inc;

  assign mz  = z_in * t_in;
  assign pr  = p1 * RECIP;
  assign rem = 38'(p2) - qe2 * KV;
  assign inc = rem >= 38'(KV);

  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= mz[59:30];
      z1    <= z_in;
      qe2   <= pr[61:32];
      p2    <= p1;
      z2    <= z1;
      t_out <= ONE_Q30 - 31'(qe2) - 31'(inc);
      z_out <= z2;
    end
  end

endmodule

FILE: src/pbg_sincos.sv
// pipelined sine and cosine of a q28 angle, q30 results
module pbg_sincos import pbg_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [39:0] angle,
  output logic signed [31:0] s,
  output logic signed [31:0] c
);

  localparam int SIN_LEN = SIN_TERMS * CELL_LAT;
  localparam int COS_LEN = COS_TERMS * CELL_LAT;

  logic [27:0] y28;
  quad_t       quad;
  logic        swap;

  logic [29:0] y_z;
  logic [29:0] z_z;
  quad_t       q_z;
  logic        sw_z;
  logic [59:0] yy;
  logic [60:0] yy_rnd;

  logic [29:0] sin_z [SIN_TERMS+1];
  logic [30:0] sin_t [SIN_TERMS+1];
  logic [29:0] cos_z [COS_TERMS+1];
  logic [30:0] cos_t [COS_TERMS+1];

  logic [29:0] side_y  [SIN_LEN];
  quad_t       side_q  [COS_LEN];
  logic        side_sw [COS_LEN];

  logic [61:0] sv_sum;
  logic [30:0] sv1;
  logic [30:0] sv2;
  logic [30:0] sv3;
  logic signed [31:0] s0;
  logic signed [31:0] c0;

  pbg_reduce u_reduce (
    .clk   (clk),
    .en    (en),
    .angle (angle),
    .y28   (y28),
    .quad  (quad),
    .swap  (swap)
  );

  assign yy     = {y28, 2'b00} * {y28, 2'b00};
  assign yy_rnd = 61'(yy) + 61'(1 << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      y_z  <= {y28, 2'b00};
      z_z  <= yy_rnd[59:30];
      q_z  <= quad;
      sw_z <= swap;
    end
  end

  assign sin_z[0] = z_z;
  assign sin_t[0] = ONE_Q30;
  assign cos_z[0] = z_z;
  assign cos_t[0] = ONE_Q30;

  for (genvar i = 0; i < SIN_TERMS; i++) begin : g_sin
    pbg_cell #(.K(SIN_K[i])) u_cell (
      .clk   (clk),
      .en    (en),
      .z_in  (sin_z[i]),
      .t_in  (sin_t[i]),
      .z_out (sin_z[i+1]),
      .t_out (sin_t[i+1])
    );
  end

  for (genvar i = 0; i < COS_TERMS; i++) begin : g_cos
    pbg_cell #(.K(COS_K[i])) u_cell (
      .clk   (clk),
      .en    (en),
      .z_in  (cos_z[i]),
      .t_in  (cos_t[i]),
      .z_out (cos_z[i+1]),
      .t_out (cos_t[i+1])
    );
  end

  // side data rides along the cell chains
  always_ff @(posedge clk) begin
    if (en) begin
      side_y[0]  <= y_z;
      side_q[0]  <= q_z;
      side_sw[0] <= sw_z;
      for (int i = 1; i < SIN_LEN; i++) begin
        side_y[i] <= side_y[i-1];
      end
      for (int i = 1; i < COS_LEN; i++) begin
        side_q[i]  <= side_q[i-1];
        side_sw[i] <= side_sw[i-1];
      end
    end
  end

  assign sv_sum = 62'(side_y[SIN_LEN-1] * sin_t[SIN_TERMS]) + 62'(1 << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      sv1 <= sv_sum[60:30];
      sv2 <= sv1;
      sv3 <= sv2;
    end
  end

  assign s0 = side_sw[COS_LEN-1] ? $signed({1'b0, cos_t[COS_TERMS]}) : $signed({1'b0, sv3});
  assign c0 = side_sw[COS_LEN-1] ? $signed({1'b0, sv3}) : $signed({1'b0, cos_t[COS_TERMS]});

  always_ff @(posedge clk) begin
    if (en) begin
      case (side_q[COS_LEN-1])
        QUAD_0: begin
          s <= s0;
          c <= c0;
        end
        QUAD_1: begin
          s <= c0;
          c <= -s0;
        end
        QUAD_2: begin
          s <= -s0;
          c <= -c0;
        end
        default: begin
          s <= -c0;
          c <= s0;
        end
      endcase
    end
  end

endmodule

FILE: src/pushbroom_pixel_to_ground_top.sv
// top level: pushbroom pixel to flat ground coordinate pipeline
// throughput: one pixel per cycle while the skid entry is free,
// set by the fully pipelined horner cell chains
// a two-entry output (register plus skid) keeps taking requests while a result waits
// reset: synchronous, clears valid flags and loads the register defaults
// no clearing pass; the block takes requests in the first cycle after reset
module pushbroom_pixel_to_ground_top import pbg_pkg::*; #(
  parameter int COLUMN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] pixel_column,
  input  logic [31:0] line_roll,
  input  logic [31:0] line_pitch,
  input  logic [31:0] line_yaw,
  input  logic [31:0] track_heading,
  input  logic [31:0] line_altitude,
  input  logic [47:0] plane_x,
  input  logic [47:0] plane_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] ground_x,
  output logic [47:0] ground_y,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // column bits above 16 never reach the 16 bit port
  localparam int CW    = (COLUMN_BITS < 16) ? COLUMN_BITS : 16;
  localparam int DW    = CW + 2;
  localparam int PW    = DW + 33;
  localparam int LW    = PW - 13;
  localparam int NSTG  = 3 + SC_LAT + 4;

  // configuration registers
  logic [31:0]        angle_per_pixel;
  logic [15:0]        line_pixels;
  logic signed [31:0] ground_elevation;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_per_pixel  <= ANGLE_PER_PIXEL_RST;
      line_pixels      <= LINE_PIXELS_RST;
      ground_elevation <= GROUND_ELEVATION_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ANGLE_PER_PIXEL:  angle_per_pixel  <= cfg_data;
        CFG_LINE_PIXELS:      line_pixels      <= cfg_data[15:0];
        CFG_GROUND_ELEVATION: ground_elevation <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the skid entry is free
  logic en;
  logic skid_valid;
  logic out_take;
  logic [NSTG-1:0] vld;

  assign en       = ~skid_valid;
  assign in_stall = skid_valid;
  assign out_take = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // stage 1: doubled column offset, height above ground, heading sum
  logic signed [DW-1:0] s1_d;
  logic signed [32:0]   s1_elev;
  logic signed [32:0]   s1_hf;
  logic signed [31:0]   s1_roll;
  logic signed [31:0]   s1_pitch;
  logic signed [47:0]   s1_px;
  logic signed [47:0]   s1_py;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d     <= $signed({1'b0, pixel_column[CW-1:0], 1'b0}) -
                  $signed({2'b00, line_pixels[CW-1:0]});
      s1_elev  <= 33'($signed(line_altitude)) - 33'(ground_elevation);
      s1_hf    <= 33'($signed(track_heading)) + 33'($signed(line_yaw));
      s1_roll  <= $signed(line_roll);
      s1_pitch <= $signed(line_pitch);
      s1_px    <= $signed(plane_x);
      s1_py    <= $signed(plane_y);
    end
  end

  // stage 2: angle per pixel times column offset
  logic signed [PW-1:0] s2_prod;
  logic signed [32:0]   s2_elev;
  logic signed [32:0]   s2_hf;
  logic signed [31:0]   s2_roll;
  logic signed [31:0]   s2_pitch;
  logic signed [47:0]   s2_px;
  logic signed [47:0]   s2_py;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_prod  <= $signed({1'b0, angle_per_pixel}) * s1_d;
      s2_elev  <= s1_elev;
      s2_hf    <= s1_hf;
      s2_roll  <= s1_roll;
      s2_pitch <= s1_pitch;
      s2_px    <= s1_px;
      s2_py    <= s1_py;
    end
  end

  // stage 3: round to q28, negate and add roll for the look angle
  logic signed [PW-1:0] s2_rnd;
  logic signed [LW-1:0] s2_look;
  logic signed [39:0]   s3_la;
  logic signed [39:0]   s3_pitch;
  logic signed [39:0]   s3_hf;
  logic signed [32:0]   s3_elev;
  logic signed [47:0]   s3_px;
  logic signed [47:0]   s3_py;

  // round half away from zero
  assign s2_rnd  = s2_prod + (s2_prod[PW-1] ? PW'(4095) : PW'(4096));
  assign s2_look = $signed(s2_rnd[PW-1:13]);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_la    <= 40'(s2_roll) - 40'(s2_look);
      s3_pitch <= 40'(s2_pitch);
      s3_hf    <= 40'(s2_hf);
      s3_elev  <= s2_elev;
      s3_px    <= s2_px;
      s3_py    <= s2_py;
    end
  end

  // three sine/cosine units in parallel, each with a sine and a cosine cell chain
  logic signed [31:0] sl;
  logic signed [31:0] cl;
  logic signed [31:0] sp;
  logic signed [31:0] cp;
  logic signed [31:0] sf;
  logic signed [31:0] cf;

  pbg_sincos u_sc_look (
    .clk   (clk),
    .en    (en),
    .angle (s3_la),
    .s     (sl),
    .c     (cl)
  );

  pbg_sincos u_sc_pitch (
    .clk   (clk),
    .en    (en),
    .angle (s3_pitch),
    .s     (sp),
    .c     (cp)
  );

  pbg_sincos u_sc_head (
    .clk   (clk),
    .en    (en),
    .angle (s3_hf),
    .s     (sf),
    .c     (cf)
  );

  // position and height delay line matching the sine/cosine latency
  logic signed [32:0] dl_elev [SC_LAT];
  logic signed [47:0] dl_px   [SC_LAT];
  logic signed [47:0] dl_py   [SC_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      dl_elev[0] <= s3_elev;
      dl_px[0]   <= s3_px;
      dl_py[0]   <= s3_py;
      for (int i = 1; i < SC_LAT; i++) begin
        dl_elev[i] <= dl_elev[i-1];
        dl_px[i]   <= dl_px[i-1];
        dl_py[i]   <= dl_py[i-1];
      end
    end
  end

  // stage p: rotation products
  logic signed [63:0] p_lc;
  logic signed [63:0] p_ps;
  logic signed [63:0] p_pc;
  logic signed [63:0] p_ls;
  logic signed [32:0] p_elev;
  logic signed [47:0] p_px;
  logic signed [47:0] p_py;

  always_ff @(posedge clk) begin
    if (en) begin
      p_lc   <= sl * cf;
      p_ps   <= sp * sf;
      p_pc   <= sp * cf;
      p_ls   <= sl * sf;
      p_elev <= dl_elev[SC_LAT-1];
      p_px   <= dl_px[SC_LAT-1];
      p_py   <= dl_py[SC_LAT-1];
    end
  end

  // stage k: rotated sines, q60 rounded to q29
  logic signed [63:0] sum_x;
  logic signed [63:0] sum_y;
  logic signed [63:0] rnd_x;
  logic signed [63:0] rnd_y;
  logic signed [31:0] k_x;
  logic signed [31:0] k_y;
  logic signed [32:0] k_elev;
  logic signed [47:0] k_px;
  logic signed [47:0] k_py;

  assign sum_x = p_lc + p_ps;
  assign sum_y = p_pc - p_ls;
  assign rnd_x = sum_x + (sum_x[63] ? 64'(1073741823) : 64'(1073741824));
  assign rnd_y = sum_y + (sum_y[63] ? 64'(1073741823) : 64'(1073741824));

  always_ff @(posedge clk) begin
    if (en) begin
      k_x    <= $signed(rnd_x[62:31]);
      k_y    <= $signed(rnd_y[62:31]);
      k_elev <= p_elev;
      k_px   <= p_px;
      k_py   <= p_py;
    end
  end

  // stage e: scale by height above ground
  logic signed [64:0] e_x;
  logic signed [64:0] e_y;
  logic signed [47:0] e_px;
  logic signed [47:0] e_py;

  always_ff @(posedge clk) begin
    if (en) begin
      e_x  <= k_x * k_elev;
      e_y  <= k_y * k_elev;
      e_px <= k_px;
      e_py <= k_py;
    end
  end

  // stage r: round to 2^-16 m
  logic signed [64:0] rnd_ex;
  logic signed [64:0] rnd_ey;
  logic signed [41:0] r_x;
  logic signed [41:0] r_y;
  logic signed [47:0] r_px;
  logic signed [47:0] r_py;

  assign rnd_ex = e_x + (e_x[64] ? 65'(4194303) : 65'(4194304));
  assign rnd_ey = e_y + (e_y[64] ? 65'(4194303) : 65'(4194304));

  always_ff @(posedge clk) begin
    if (en) begin
      r_x  <= $signed(rnd_ex[64:23]);
      r_y  <= $signed(rnd_ey[64:23]);
      r_px <= e_px;
      r_py <= e_py;
    end
  end

  // final add with saturation feeds the output register or the skid entry
  logic signed [48:0] gx_sum;
  logic signed [48:0] gy_sum;
  logic [47:0]        gx_new;
  logic [47:0]        gy_new;
  logic [47:0]        skid_x;
  logic [47:0]        skid_y;
  logic               vld_last;

  assign gx_sum   = 49'(r_x) + 49'(r_px);
  assign gy_sum   = 49'(r_y) + 49'(r_py);
  assign gx_new   = sat48(gx_sum);
  assign gy_new   = sat48(gy_sum);
  assign vld_last = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // pipeline frozen; skid drains into the output register
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (vld_last) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        ground_x <= skid_x;
        ground_y <= skid_y;
      end
    end else if (vld_last) begin
      if (!out_valid || out_take) begin
        ground_x <= gx_new;
        ground_y <= gy_new;
      end else begin
        skid_x <= gx_new;
        skid_y <= gy_new;
      end
    end
  end

endmodule

FILE: src/pbg_checker.sv
// port level checks for the pixel to ground top level, bound to it
module pbg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [47:0] ground_x,
  input logic [47:0] ground_y
);

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a waiting result keeps its payload
  a_out_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(ground_x) && $stable(ground_y))
    else $error("result payload changed while stalled");

  // the input side stalls only behind a full output register
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // once the output request is taken the held result moves up and input opens
  a_stall_clears: assert property (@(posedge clk) disable iff (rst)
    in_stall && !out_stall |=> !in_stall && out_valid)
    else $error("skid entry did not drain");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("valid after reset");

endmodule

bind pushbroom_pixel_to_ground_top pbg_checker u_pbg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .ground_x  (ground_x),
  .ground_y  (ground_y)
);

FILE: tb/sv/tb_pushbroom_pixel_to_ground_top.sv
// testbench for the pushbroom pixel to ground pipeline: directed table plus random pixels
`timescale 1ns / 100ps

module tb_pushbroom_pixel_to_ground_top;
  import pbg_pkg::*;

  localparam int          COLUMN_BITS = 16;
  localparam int          DRAIN_CYCLES = 60;      // well past the pipeline latency
  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [1:0]  CFG_SPARE = 2'd3;       // unmapped register index
  localparam longint      SAT_MAX = 64'sd140737488355327;
  localparam longint      SAT_MIN = -64'sd140737488355328;
  localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] POS_MIN = 48'h8000_0000_0000;

  // one pixel request
  typedef struct {
    logic [15:0] col;
    logic [31:0] roll;
    logic [31:0] pitch;
    logic [31:0] yaw;
    logic [31:0] head;
    logic [31:0] alt;
    logic [47:0] px;
    logic [47:0] py;
    bit          typed;   // hand-typed ground position below
    logic [47:0] ex;
    logic [47:0] ey;
  } pixel_req_t;

  typedef struct {
    logic [47:0] gx;
    logic [47:0] gy;
  } ground_pos_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] pixel_column = '0;
  logic [31:0] line_roll = '0;
  logic [31:0] line_pitch = '0;
  logic [31:0] line_yaw = '0;
  logic [31:0] track_heading = '0;
  logic [31:0] line_altitude = '0;
  logic [47:0] plane_x = '0;
  logic [47:0] plane_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [47:0] ground_x;
  logic [47:0] ground_y;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // local copy of the configuration registers
  logic [31:0] m_angle_per_pixel = ANGLE_PER_PIXEL_RST;
  logic [15:0] m_line_pixels = LINE_PIXELS_RST;
  logic [31:0] m_ground_elev = GROUND_ELEVATION_RST;

  ground_pos_t expected_ground[$];
  pixel_req_t  directed_rows[$];
  int          errors = 0;
  int          cycle_count = 0;
  bit          no_gaps = 1'b0;   // long stretch without idling on either side

  pushbroom_pixel_to_ground_top #(.COLUMN_BITS(COLUMN_BITS)) dut (.*);

  always #5 clk = ~clk;

  // round to nearest, halves away from zero
  function automatic longint round_shift(longint v, int sh);
    longint half;
    half = 64'sd1 <<< (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  // taylor sin/cos on [0, pi/4], q28 in, q30 out, truncating horner steps
  function automatic void taylor_sc(input longint unsigned y28,
                                    output longint unsigned sv, output longint unsigned cv);
    longint unsigned y, z, t, one;
    one = 64'd1 << 30;
    y = y28 << 2;
    z = (y * y + (64'd1 << 29)) >> 30;
    t = one;
    for (int i = 0; i < SIN_TERMS; i++) t = one - ((z * t) >> 30) / longint'(SIN_K[i]);
    sv = (y * t + (64'd1 << 29)) >> 30;
    t = one;
    for (int i = 0; i < COS_TERMS; i++) t = one - ((z * t) >> 30) / longint'(COS_K[i]);
    cv = t;
  endfunction

  // reduce to a quadrant, fold to [0, pi/4], then unfold the signs
  function automatic void angle_sincos(input longint a, output longint s, output longint c);
    longint hpi, r, x, s0, c0;
    longint unsigned ps, pc;
    quad_t q;
    hpi = longint'(HPI_Q28);
    r = a % (4 * hpi);
    if (r < 0) r += 4 * hpi;
    q = quad_t'(r / hpi);
    x = r - longint'(q) * hpi;
    if (x > longint'(QPI_Q28)) begin
      taylor_sc(hpi - x, ps, pc);
      s0 = pc;
      c0 = ps;
    end else begin
      taylor_sc(x, ps, pc);
      s0 = ps;
      c0 = pc;
    end
    case (q)
      QUAD_0: begin s = s0; c = c0; end
      QUAD_1: begin s = c0; c = -s0; end
      QUAD_2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endfunction

  function automatic logic [47:0] clamp48(longint v);
    if (v > SAT_MAX) return POS_MAX;
    if (v < SAT_MIN) return POS_MIN;
    return v[47:0];
  endfunction

  function automatic ground_pos_t georeference(pixel_req_t r);
    longint col, wid, d, look, elev, sl, cl, sp, cp, sf, cf, kx, ky;
    ground_pos_t g;
    col = longint'(r.col) & ((64'sd1 <<< COLUMN_BITS) - 1);
    wid = longint'(m_line_pixels) & ((64'sd1 <<< COLUMN_BITS) - 1);
    d = 2 * col - wid;
    look = -round_shift(longint'(m_angle_per_pixel) * d, 13);
    elev = longint'(signed'(r.alt)) - longint'(signed'(m_ground_elev));
    angle_sincos(look + longint'(signed'(r.roll)), sl, cl);
    angle_sincos(longint'(signed'(r.pitch)), sp, cp);
    angle_sincos(longint'(signed'(r.head)) + longint'(signed'(r.yaw)), sf, cf);
    kx = round_shift(sl * cf + sp * sf, 31);
    ky = round_shift(sp * cf - sl * sf, 31);
    g.gx = clamp48(round_shift(kx * elev, 23) + longint'(signed'(r.px)));
    g.gy = clamp48(round_shift(ky * elev, 23) + longint'(signed'(r.py)));
    return g;
  endfunction

  // registers only change while the pipe is empty
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_ANGLE_PER_PIXEL:  m_angle_per_pixel = val;
      CFG_LINE_PIXELS:      m_line_pixels = val[15:0];
      CFG_GROUND_ELEVATION: m_ground_elev = val;
      default: ;   // unmapped index is ignored
    endcase
  endtask

  task automatic wait_idle();
    while (expected_ground.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // drive one request, hold it until taken, queue its predicted ground position
  task automatic send_pixel(pixel_req_t r);
    ground_pos_t g;
    if (!no_gaps && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_column <= r.col;
    line_roll <= r.roll;
    line_pitch <= r.pitch;
    line_yaw <= r.yaw;
    track_heading <= r.head;
    line_altitude <= r.alt;
    plane_x <= r.px;
    plane_y <= r.py;
    g = georeference(r);
    if (r.typed) begin
      g.gx = r.ex;
      g.gy = r.ey;
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_ground.push_back(g);
  endtask

  function automatic pixel_req_t nav_row(logic [15:0] col, logic [31:0] roll, logic [31:0] pitch,
                                         logic [31:0] yaw, logic [31:0] head, logic [31:0] alt,
                                         logic [47:0] px, logic [47:0] py);
    pixel_req_t r;
    r.col = col; r.roll = roll; r.pitch = pitch; r.yaw = yaw; r.head = head;
    r.alt = alt; r.px = px; r.py = py;
    r.typed = 1'b0; r.ex = '0; r.ey = '0;
    return r;
  endfunction

  function automatic pixel_req_t typed_row(pixel_req_t r, logic [47:0] ex, logic [47:0] ey);
    r.typed = 1'b1;
    r.ex = ex;
    r.ey = ey;
    return r;
  endfunction

  // mostly plausible flight data, some raw bit noise and some near the position limits
  function automatic pixel_req_t random_pixel();
    pixel_req_t r;
    int unsigned kind;
    kind = $urandom_range(99);
    r = nav_row(16'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
    if (kind < 65) begin
      r.col = 16'($urandom_range(0, m_line_pixels));
      r.roll = $urandom_range(0, 160000000) - 80000000;     // about +-0.3 rad
      r.pitch = $urandom_range(0, 80000000) - 40000000;
      r.yaw = $urandom_range(0, 40000000) - 20000000;
      r.head = $urandom_range(0, 1686629712) - 843314856; // +-pi
      r.alt = m_ground_elev + $urandom_range(100 << 10, 6000 << 10);
      r.px = 48'(longint'($urandom_range(0, 1000000)) <<< 16);
      r.py = 48'(longint'($urandom_range(0, 6000000)) <<< 16);
    end else if (kind < 80) begin
      r.px = $urandom_range(1) ? POS_MAX - $urandom_range(0, 1 << 30)
                               : POS_MIN + $urandom_range(0, 1 << 30);
      r.py = $urandom_range(1) ? POS_MAX - $urandom_range(0, 1 << 30)
                               : POS_MIN + $urandom_range(0, 1 << 30);
    end
    return r;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_pixel(random_pixel());
  endtask

  // result side: random backpressure and in-order compare
  always @(posedge clk) begin
    ground_pos_t g;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      if (expected_ground.size() == 0) begin
        $error("unexpected result ground_x=%h ground_y=%h", ground_x, ground_y);
        errors++;
      end else begin
        g = expected_ground.pop_front();
        if (ground_x !== g.gx) begin
          $error("ground_x expected %h got %h", g.gx, ground_x);
          errors++;
        end
        if (ground_y !== g.gy) begin
          $error("ground_y expected %h got %h", g.gy, ground_y);
          errors++;
        end
      end
    end
    out_stall <= !no_gaps && ($urandom_range(99) < 25);
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // directed rows, default registers: width 6144 so column 3072 looks straight down
    directed_rows.push_back(typed_row(nav_row(16'd3072, 0, 0, 0, 0, 0, 0, 0), 0, 0));
    directed_rows.push_back(typed_row(nav_row(16'd3072, 0, 0, 0, 0, 32'h7FFF_FFFF,
                                              POS_MAX, POS_MIN), POS_MAX, POS_MIN));
    // height above ground zero: any attitude leaves the plane position unchanged
    directed_rows.push_back(typed_row(nav_row(16'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                                              32'h7FFF_FFFF, 32'h8000_0000,
                                              GROUND_ELEVATION_RST, 48'h1234_5678_9ABC,
                                              48'hFEDC_BA98_7654),
                                      48'h1234_5678_9ABC, 48'hFEDC_BA98_7654));
    // nose straight down at full altitude drives northing into the clamp
    directed_rows.push_back(typed_row(nav_row(16'd3072, 0, 32'(HPI_Q28), 0, 0,
                                              32'h7FFF_FFFF, 0, POS_MAX), 0, POS_MAX));
    directed_rows.push_back(typed_row(nav_row(16'd3072, 0, -32'(HPI_Q28), 0, 0,
                                              32'h7FFF_FFFF, 0, POS_MIN), 0, POS_MIN));
    // column extremes, past the width included
    directed_rows.push_back(nav_row(16'd0, 0, 0, 0, 0, 32'd1024000, 0, 0));
    directed_rows.push_back(nav_row(16'd6144, 0, 0, 0, 0, 32'd1024000, 0, 0));
    directed_rows.push_back(nav_row(16'hFFFF, 0, 0, 0, 0, 32'd1024000, 0, 0));
    // attitude extremes and angles far outside one turn
    directed_rows.push_back(nav_row(16'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'd2048000, 0, 0));
    directed_rows.push_back(nav_row(16'd5000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h8000_0000, POS_MAX, POS_MIN));
    // fold and quadrant edges
    directed_rows.push_back(nav_row(16'd3072, 32'(QPI_Q28), 32'(QPI_Q28) + 1,
                                    32'(HPI_Q28), 32'(HPI2_Q28), 32'd3000000, 0, 0));
    directed_rows.push_back(nav_row(16'd3072, 32'(HPI3_Q28), -32'(QPI_Q28),
                                    32'(RED_PERIOD), -32'(HPI3_Q28), 32'd3000000, 0, 0));
    directed_rows.push_back(nav_row(16'd3073, 32'(RED_PERIOD) - 1, 32'(HPI_Q28) - 1,
                                    0, -32'(RED_PERIOD), 32'd3000000, POS_MIN, POS_MAX));
    directed_rows.push_back(nav_row(16'd2000, 32'd10000000, 32'd5000000, 32'd1000000,
                                    32'd843314856, 32'h8000_0000, 48'h0000_FFFF_0000, 0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // defaults from reset
    foreach (directed_rows[i]) send_pixel(directed_rows[i]);
    random_phase(80);
    in_valid <= 1'b0;
    wait_idle();

    // smallest settings: zero angle step, width one, lowest ground
    write_reg(CFG_ANGLE_PER_PIXEL, 32'd0);
    write_reg(CFG_LINE_PIXELS, 32'd1);
    write_reg(CFG_GROUND_ELEVATION, 32'h8000_0000);
    random_phase(70);
    in_valid <= 1'b0;
    wait_idle();

    // largest settings, run without any idling
    write_reg(CFG_ANGLE_PER_PIXEL, 32'hFFFF_FFFF);
    write_reg(CFG_LINE_PIXELS, 32'h0000_FFFF);
    write_reg(CFG_GROUND_ELEVATION, 32'h7FFF_FFFF);
    no_gaps = 1'b1;
    random_phase(80);
    in_valid <= 1'b0;
    wait_idle();
    no_gaps = 1'b0;

    // zero width: centre at column zero
    write_reg(CFG_LINE_PIXELS, 32'd0);
    write_reg(CFG_ANGLE_PER_PIXEL, $urandom);
    write_reg(CFG_GROUND_ELEVATION, $urandom_range(0, 2000 << 10));
    random_phase(60);
    in_valid <= 1'b0;
    wait_idle();

    // odd width, plausible angle step, spare index must change nothing
    write_reg(CFG_LINE_PIXELS, ($urandom_range(1, 32767) << 1) | 1);
    write_reg(CFG_ANGLE_PER_PIXEL, $urandom_range(20000000, 400000000));
    write_reg(CFG_GROUND_ELEVATION, $urandom_range(0, 3000 << 10));
    write_reg(CFG_SPARE, $urandom);
    random_phase(90);
    in_valid <= 1'b0;

    while (expected_ground.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/pbg_pkg.sv
src/pbg_reduce.sv
src/pbg_cell.sv
src/pbg_sincos.sv
src/pushbroom_pixel_to_ground_top.sv
src/pbg_checker.sv
tb/sv/tb_pushbroom_pixel_to_ground_top.sv
